@@ hdl/xtrie_pkg.sv @@
package xtrie_pkg;

  // Fixed widths of the item and result fields.
  localparam int ValueW  = 10;
  localparam int CountW  = 11;
  localparam int ActionW = 3;

  // Action codes of an input item; the two codes above clear are unused.
  typedef enum logic [ActionW-1:0] {
    ACT_INSERT  = 3'd0,
    ACT_ERASE   = 3'd1,
    ACT_XOR_MIN = 3'd2,
    ACT_XOR_MAX = 3'd3,
    ACT_COUNT   = 3'd4,
    ACT_CLEAR   = 3'd5
  } action_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_UP_RD,
    S_UP_WR,
    S_WALK_RD,
    S_WALK_CHK,
    S_LEAF_RD,
    S_LEAF_CHK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [ValueW-1:0] xor_answer;
    logic              present;
    logic              empty_error;
    logic [CountW-1:0] element_count;
  } result_t;

  typedef struct packed {
    logic    load;
    result_t res;
  } out_load_t;

endpackage

@@ hdl/xor_min_max_bit_trie_set.sv @@
// Set of unsigned values held as a binary trie of prefix counts in one
// synchronous RAM of 2 << VALUE_BITS entries (node 1 is the root, node n has
// children 2n and 2n+1, leaves sit at (1 << VALUE_BITS) + value).
// An item enters on item_valid/item_ready with action and value; exactly one
// result leaves on result_valid/result_ready for every item.
// Each item is worked on alone, one trie level at a time through the single
// RAM port, whose read data is registered:
//   insert, erase: a read and a write per level from the leaf up to the root,
//                  stopping at the leaf when the value is already in or out;
//   xor_min, xor_max: a read per level from the root down, none on an empty set;
//   count: a single read of the leaf; unused actions: no RAM access;
//   clear: a sweep that zeroes every entry of the RAM.
// After reset the same sweep runs with
// item_ready low and no result produced.
// The result waits in an output register; while the receiver stalls, the
// next item is still taken and worked on, and only its final hand-off waits
// until the output register is free.
module xor_min_max_bit_trie_set #(
  parameter int VALUE_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic [2:0]                  action,
  input  logic [9:0]                  value,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [9:0]                  xor_answer,
  output logic                        present,
  output logic                        empty_error,
  output logic [10:0]                 element_count
);

  import xtrie_pkg::*;

  localparam int NodeW = VALUE_BITS + 1;
  localparam int Depth = 2 << VALUE_BITS;
  localparam logic [NodeW-1:0] Root      = NodeW'(1);
  localparam logic [NodeW-1:0] LeafCount = NodeW'(1) << VALUE_BITS;

  state_t state, state_next;

  logic [NodeW-1:0]      node;
  logic [VALUE_BITS-1:0] tgt;
  logic [VALUE_BITS-1:0] val;
  logic [ActionW-1:0]    op;
  logic [VALUE_BITS-1:0] ans;
  logic                  present_q;
  logic                  err_q;
  logic [NodeW-1:0]      size;
  logic [NodeW-1:0]      clr_addr;
  logic                  clr_resp;

  logic [NodeW-1:0]      mem_addr;
  logic                  mem_we;
  logic [NodeW-1:0]      mem_wdata;
  logic [NodeW-1:0]      mem_rdata;

  logic                  accept;
  logic                  slot_free;
  out_load_t             ld;
  result_t               res_q;

  // Width adaptation between the fixed ports and the trie width.
  logic [VALUE_BITS+9:0]  value_wide;
  logic [VALUE_BITS-1:0]  v_in;
  logic [VALUE_BITS+9:0]  ans_wide;
  logic [VALUE_BITS+11:0] size_wide;

  assign value_wide = {{VALUE_BITS{1'b0}}, value};
  assign v_in       = value_wide[VALUE_BITS-1:0];
  assign ans_wide   = {10'b0, ans};
  assign size_wide  = {11'b0, size};

  assign accept = item_valid && item_ready;

  // Update step on a trie node on the way from the leaf to the root.
  logic             rd_nonzero;
  logic             is_insert;
  logic             no_change;
  logic [NodeW-1:0] upd_count;
  logic             clr_last;

  assign rd_nonzero = (mem_rdata != '0);
  assign is_insert  = (op == ACT_INSERT);
  // At the leaf, an insert of a member or an erase of a non-member stops.
  assign no_change  = node[VALUE_BITS] && (is_insert == rd_nonzero);
  assign upd_count  = is_insert ? mem_rdata + NodeW'(1) : mem_rdata - NodeW'(1);
  assign clr_last   = (clr_addr == NodeW'(Depth - 1));

  // One step of the xor walk: keep the preferred branch if it holds a member.
  logic             dir;
  logic [NodeW-1:0] node_step;

  assign dir       = rd_nonzero ? tgt[VALUE_BITS-1] : ~tgt[VALUE_BITS-1];
  assign node_step = {node[VALUE_BITS-1:0], dir};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_last) begin
          state_next = clr_resp ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          case (action) inside
            ACT_INSERT, ACT_ERASE: state_next = S_UP_RD;
            ACT_XOR_MIN, ACT_XOR_MAX: begin
              state_next = (size == '0) ? S_RESP : S_WALK_RD;
            end
            ACT_COUNT: state_next = S_LEAF_RD;
            ACT_CLEAR: state_next = S_CLEAR;
            default:   state_next = S_RESP;
          endcase
        end
      end
      S_UP_RD:    state_next = S_UP_WR;
      S_UP_WR:    state_next = (no_change || node == Root) ? S_RESP : S_UP_RD;
      S_WALK_RD:  state_next = S_WALK_CHK;
      S_WALK_CHK: state_next = node_step[VALUE_BITS] ? S_RESP : S_WALK_RD;
      S_LEAF_RD:  state_next = S_LEAF_CHK;
      S_LEAF_CHK: state_next = S_RESP;
      S_RESP:     state_next = slot_free ? S_IDLE : S_RESP;
      default:    state_next = S_CLEAR;
    endcase
  end

  // Outputs of the state machine: RAM port, input ready, result load.
  always_comb begin
    mem_addr   = node;
    mem_we     = 1'b0;
    mem_wdata  = upd_count;
    item_ready = 1'b0;
    ld.load    = 1'b0;
    ld.res.xor_answer    = ans_wide[9:0];
    ld.res.present       = present_q;
    ld.res.empty_error   = err_q;
    ld.res.element_count = size_wide[10:0];
    unique case (state)
      S_CLEAR: begin
        mem_addr  = clr_addr;
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      S_IDLE:    item_ready = 1'b1;
      S_UP_WR:   mem_we = !no_change;
      S_WALK_RD: mem_addr = {node[VALUE_BITS-1:0], tgt[VALUE_BITS-1]};
      S_RESP:    ld.load = slot_free;
      default: begin
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      clr_resp <= 1'b0;
      size     <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && accept && action == ACT_CLEAR) begin
        clr_addr <= '0;
        clr_resp <= 1'b1;
        size     <= '0;
      end
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + NodeW'(1);
        if (clr_last) begin
          clr_resp <= 1'b0;
        end
      end
      if (state == S_UP_WR && !no_change && node == Root) begin
        size <= upd_count;
      end
    end
  end

  // Working registers of the item in progress.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op        <= action;
          val       <= v_in;
          ans       <= '0;
          present_q <= 1'b0;
          err_q     <= (action == ACT_XOR_MIN || action == ACT_XOR_MAX) && size == '0;
          tgt       <= (action == ACT_XOR_MAX) ? ~v_in : v_in;
          if (action == ACT_XOR_MIN || action == ACT_XOR_MAX) begin
            node <= Root;
          end else begin
            node <= {1'b1, v_in};
          end
        end
      end
      S_UP_WR: begin
        node <= node >> 1;
      end
      S_WALK_CHK: begin
        node <= node_step;
        tgt  <= tgt << 1;
        ans  <= node_step[VALUE_BITS-1:0] ^ val;
      end
      S_LEAF_CHK: begin
        present_q <= rd_nonzero;
      end
      default: begin
      end
    endcase
  end

  xtrie_ram #(
    .WIDTH(NodeW),
    .DEPTH(Depth)
  ) u_counts (
    .clk  (clk),
    .addr (mem_addr),
    .we   (mem_we),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  xtrie_out u_out (
    .clk         (clk),
    .rst         (rst),
    .ld          (ld),
    .slot_free   (slot_free),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .res_q       (res_q)
  );

  assign xor_answer    = res_q.xor_answer;
  assign present       = res_q.present;
  assign empty_error   = res_q.empty_error;
  assign element_count = res_q.element_count;

`ifndef NO_ASSERTIONS
  // A result is never loaded over one that the receiver has not taken.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ld.load |-> (!result_valid || result_ready))
    else $error("result loaded into a full output register");

  // An accepted item always takes the block out of the ready state.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !item_ready)
    else $error("block still ready right after accepting an item");

  // The member count can never exceed the number of distinct values.
  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    size <= LeafCount)
    else $error("member count above the value range");
`endif

endmodule

@@ hdl/xtrie_ram.sv @@
module xtrie_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hdl/xtrie_out.sv @@
module xtrie_out (
  input  logic                  clk,
  input  logic                  rst,
  input  xtrie_pkg::out_load_t  ld,
  output logic                  slot_free,
  output logic                  result_valid,
  input  logic                  result_ready,
  output xtrie_pkg::result_t    res_q
);

  import xtrie_pkg::*;

  // The slot can take a new result when it is empty or is being emptied now.
  assign slot_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ld.load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      res_q <= ld.res;
    end
  end

endmodule
